### hdl/sspl_pkg.sv
// ----------------------------------------------------------------------------
// sspl_pkg
// shared widths, codes and types of the stable sorted priority list
// ----------------------------------------------------------------------------
package sspl_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam int KIND_W      = 2;
    localparam int SCORE_W     = 8;
    localparam int TAG_W       = 16;
    localparam int PRI_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USED_W  = STATUS_W + PRI_W + SCORE_W + TAG_W + FILL_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ENTRY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_TOP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_TOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_MID  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_LOW  = 3'd6;

    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

endpackage

### hdl/sspl_classify.sv
// ----------------------------------------------------------------------------
// sspl_classify
// threshold and priority registers, score to priority class mapping
// ----------------------------------------------------------------------------
module sspl_classify
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sspl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sspl_pkg::SCORE_W-1:0]        score,
    output logic [sspl_pkg::PRI_W-1:0]          priority_class
);

    logic [sspl_pkg::SCORE_W-1:0] thr_top_reg;
    logic [sspl_pkg::SCORE_W-1:0] thr_high_reg;
    logic [sspl_pkg::SCORE_W-1:0] thr_mid_reg;
    logic [sspl_pkg::PRI_W-1:0]   pri_top_reg;
    logic [sspl_pkg::PRI_W-1:0]   pri_high_reg;
    logic [sspl_pkg::PRI_W-1:0]   pri_mid_reg;
    logic [sspl_pkg::PRI_W-1:0]   pri_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_top_reg  <= 8'd9;
            thr_high_reg <= 8'd8;
            thr_mid_reg  <= 8'd6;
            pri_top_reg  <= 3'd1;
            pri_high_reg <= 3'd2;
            pri_mid_reg  <= 3'd3;
            pri_low_reg  <= 3'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sspl_pkg::CFG_THR_TOP:  thr_top_reg  <= cfg_data;
                sspl_pkg::CFG_THR_HIGH: thr_high_reg <= cfg_data;
                sspl_pkg::CFG_THR_MID:  thr_mid_reg  <= cfg_data;
                sspl_pkg::CFG_PRI_TOP:  pri_top_reg  <= cfg_data[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_HIGH: pri_high_reg <= cfg_data[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_MID:  pri_mid_reg  <= cfg_data[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_LOW:  pri_low_reg  <= cfg_data[sspl_pkg::PRI_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // tests run in fixed order top, high, mid
    always_comb
    begin
        if (score >= thr_top_reg)
        begin
            priority_class = pri_top_reg;
        end
        else if (score >= thr_high_reg)
        begin
            priority_class = pri_high_reg;
        end
        else if (score >= thr_mid_reg)
        begin
            priority_class = pri_mid_reg;
        end
        else
        begin
            priority_class = pri_low_reg;
        end
    end

endmodule

### hdl/stable_sorted_priority_list.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_list
// bounded list of scored entries kept in ascending priority order
// ----------------------------------------------------------------------------
// Entries live in a single slot memory with one write and one registered read
// per cycle, driven by a small sequencer that compares one slot per step. An
// insert walks from the tail toward the head, moving each entry of higher
// priority one slot back; each step reads a slot (S_SCAN) and compares it
// (S_CMP), then S_PLACE writes the new entry and S_RESP loads its result. A
// read-out alternates S_RREQ and S_RSEND, so it sends no entry back to back;
// a clear or a dropped insert goes straight to S_RESP. The input is not ready
// until the item's last result has been loaded into the output register; an
// unused kind code is taken and dropped.
// ----------------------------------------------------------------------------
module stable_sorted_priority_list
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sspl_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // score, tag
    input  logic [sspl_pkg::KIND_W-1:0]         s_axis_tuser,   // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sspl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // status, priority_res,
                                                                // entry_score, entry_tag,
                                                                // fill
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [sspl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_PLACE,
        S_RESP,
        S_RREQ,
        S_RSEND
    } state_t;

    state_t                             state_reg, state_next;
    logic [sspl_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [sspl_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [sspl_pkg::CNT_W-1:0]         nread_reg, nread_next;
    logic [sspl_pkg::PRI_W-1:0]         pri_reg, pri_next;
    logic [sspl_pkg::SCORE_W-1:0]       score_reg, score_next;
    logic [sspl_pkg::TAG_W-1:0]         tag_reg, tag_next;
    logic [sspl_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic                               out_valid_reg, out_valid_next;
    logic [sspl_pkg::OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                               out_last_reg, out_last_next;

    sspl_pkg::entry_t                   slot_mem [sspl_pkg::CAPACITY];
    sspl_pkg::entry_t                   rdata_reg;
    logic                               mem_we;
    logic                               mem_re;
    logic [sspl_pkg::IDX_W-1:0]         mem_waddr;
    logic [sspl_pkg::IDX_W-1:0]         mem_raddr;
    sspl_pkg::entry_t                   mem_wdata;

    logic [sspl_pkg::PRI_W-1:0]         cls_pri;
    logic                               in_fire;
    logic                               out_free;
    logic                               read_last;
    logic [31:0]                        fill_ext;

    function automatic logic [sspl_pkg::OUT_DATA_W-1:0] pack_result(
        input logic [sspl_pkg::STATUS_W-1:0] status,
        input sspl_pkg::entry_t              ent,
        input logic [sspl_pkg::FILL_W-1:0]   fill
    );
        logic [sspl_pkg::OUT_USED_W-1:0] used;
        used = {fill, ent.tag, ent.score, ent.pri, status};
        return sspl_pkg::OUT_DATA_W'(used);
    endfunction

    sspl_classify u_classify
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .score          (s_axis_tdata[sspl_pkg::SCORE_W-1:0]),
        .priority_class (cls_pri)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fill_ext      = 32'(count_reg);
    assign read_last     = ((sspl_pkg::CNT_W'(idx_reg) + 1'b1) == nread_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        nread_next     = nread_reg;
        pri_next       = pri_reg;
        score_next     = score_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = idx_reg;
        mem_raddr      = idx_reg;
        mem_wdata      = '{pri: pri_reg, score: score_reg, tag: tag_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    score_next = s_axis_tdata[sspl_pkg::SCORE_W-1:0];
                    tag_next   = s_axis_tdata[sspl_pkg::SCORE_W +: sspl_pkg::TAG_W];
                    pri_next   = cls_pri;
                    case (s_axis_tuser)
                        sspl_pkg::KIND_INSERT:
                        begin
                            if (32'(count_reg) >= sspl_pkg::CAPACITY)
                            begin
                                status_next = sspl_pkg::STATUS_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg[sspl_pkg::IDX_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        sspl_pkg::KIND_READ:
                        begin
                            pri_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = sspl_pkg::STATUS_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                if (32'(count_reg) > sspl_pkg::MAX_RESULTS)
                                begin
                                    nread_next = sspl_pkg::CNT_W'(sspl_pkg::MAX_RESULTS);
                                end
                                else
                                begin
                                    nread_next = count_reg;
                                end
                                idx_next   = '0;
                                state_next = S_RREQ;
                            end
                        end
                        sspl_pkg::KIND_CLEAR:
                        begin
                            pri_next    = '0;
                            count_next  = '0;
                            status_next = sspl_pkg::STATUS_OK;
                            state_next  = S_RESP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg - 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // equal priorities stay in front of the new entry
                if (rdata_reg.pri > pri_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rdata_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                mem_we      = 1'b1;
                count_next  = count_reg + 1'b1;
                status_next = sspl_pkg::STATUS_OK;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pack_result(status_reg,
                                                 '{pri: pri_reg, score: '0, tag: '0},
                                                 fill_ext[sspl_pkg::FILL_W-1:0]);
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RREQ:
            begin
                mem_re     = 1'b1;
                state_next = S_RSEND;
            end
            S_RSEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pack_result(sspl_pkg::STATUS_ENTRY, rdata_reg,
                                                 fill_ext[sspl_pkg::FILL_W-1:0]);
                    out_last_next  = read_last;
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RREQ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            nread_reg     <= '0;
            pri_reg       <= '0;
            score_reg     <= '0;
            tag_reg       <= '0;
            status_reg    <= sspl_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            nread_reg     <= nread_next;
            pri_reg       <= pri_next;
            score_reg     <= score_next;
            tag_reg       <= tag_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stable sorted priority list
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the list and of the class thresholds and
// predicts every result of each accepted command: insert, read-out, clear and
// the unused kind. A directed run covers the field extremes, equal classes,
// overflow, empty reads and clears. Random commands then follow under four
// traffic profiles with the thresholds reprogrammed between them. One profile
// includes a long output hold-off while commands keep coming.
// ----------------------------------------------------------------------------
module tb;

    localparam int RUN_ITEMS    = 38;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [sspl_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [sspl_pkg::STATUS_W-1:0] status;
        logic [sspl_pkg::PRI_W-1:0]    pri;
        logic [sspl_pkg::SCORE_W-1:0]  score;
        logic [sspl_pkg::TAG_W-1:0]    tag;
        logic [sspl_pkg::FILL_W-1:0]   fill;
        logic                          last;
    } list_result_t;

    class sorted_list_scoreboard;
        logic [sspl_pkg::SCORE_W-1:0] thr_top, thr_high, thr_mid;
        logic [sspl_pkg::PRI_W-1:0]   pri_top, pri_high, pri_mid, pri_low;
        sspl_pkg::entry_t             slots [sspl_pkg::CAPACITY];
        int unsigned                  held;
        list_result_t                 pending_q [$];
        int unsigned                  mismatches;

        function new();
            thr_top  = 8'd9;
            thr_high = 8'd8;
            thr_mid  = 8'd6;
            pri_top  = 3'd1;
            pri_high = 3'd2;
            pri_mid  = 3'd3;
            pri_low  = 3'd5;
            held = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [sspl_pkg::CFG_IDX_W-1:0] idx,
                                logic [sspl_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sspl_pkg::CFG_THR_TOP:  thr_top  = val;
                sspl_pkg::CFG_THR_HIGH: thr_high = val;
                sspl_pkg::CFG_THR_MID:  thr_mid  = val;
                sspl_pkg::CFG_PRI_TOP:  pri_top  = val[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_HIGH: pri_high = val[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_MID:  pri_mid  = val[sspl_pkg::PRI_W-1:0];
                sspl_pkg::CFG_PRI_LOW:  pri_low  = val[sspl_pkg::PRI_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [sspl_pkg::PRI_W-1:0] class_of(logic [sspl_pkg::SCORE_W-1:0] score);
            if (score >= thr_top)
                return pri_top;
            if (score >= thr_high)
                return pri_high;
            if (score >= thr_mid)
                return pri_mid;
            return pri_low;
        endfunction

        function void push(logic [sspl_pkg::STATUS_W-1:0] st, logic [sspl_pkg::PRI_W-1:0] p,
                           logic [sspl_pkg::SCORE_W-1:0] sc, logic [sspl_pkg::TAG_W-1:0] tg,
                           logic last);
            list_result_t r;
            r.status = st;
            r.pri    = p;
            r.score  = sc;
            r.tag    = tg;
            r.fill   = held[sspl_pkg::FILL_W-1:0];
            r.last   = last;
            pending_q.push_back(r);
        endfunction

        function void note_input(logic [sspl_pkg::KIND_W-1:0] kind,
                                 logic [sspl_pkg::SCORE_W-1:0] score,
                                 logic [sspl_pkg::TAG_W-1:0] tag);
            logic [sspl_pkg::PRI_W-1:0] p;
            int unsigned pos;
            int unsigned n;
            case (kind)
                sspl_pkg::KIND_INSERT:
                begin
                    p = class_of(score);
                    if (held >= sspl_pkg::CAPACITY)
                    begin
                        push(sspl_pkg::STATUS_FULL, p, '0, '0, 1'b1);
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < held && slots[pos].pri <= p)
                            pos++;
                        for (int i = held; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos].pri   = p;
                        slots[pos].score = score;
                        slots[pos].tag   = tag;
                        held++;
                        push(sspl_pkg::STATUS_OK, p, '0, '0, 1'b1);
                    end
                end
                sspl_pkg::KIND_READ:
                begin
                    n = (held > sspl_pkg::MAX_RESULTS) ? sspl_pkg::MAX_RESULTS : held;
                    if (n == 0)
                        push(sspl_pkg::STATUS_EMPTY, '0, '0, '0, 1'b1);
                    for (int i = 0; i < n; i++)
                        push(sspl_pkg::STATUS_ENTRY, slots[i].pri, slots[i].score,
                             slots[i].tag, i == n - 1);
                end
                sspl_pkg::KIND_CLEAR:
                begin
                    held = 0;
                    push(sspl_pkg::STATUS_OK, '0, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [sspl_pkg::OUT_DATA_W-1:0] data, logic last);
            list_result_t exp_r;
            list_result_t act;
            act.status = data[1:0];
            act.pri    = data[4:2];
            act.score  = data[12:5];
            act.tag    = data[28:13];
            act.fill   = data[33:29];
            act.last   = last;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d pri=%0d score=%0d tag=%h fill=%0d last=%0b",
                             act.status, act.pri, act.score, act.tag, act.fill, act.last);
                return;
            end
            exp_r = pending_q.pop_front();
            if (act != exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp st=%0d pri=%0d score=%0d tag=%h fill=%0d",
                              " last=%0b / got st=%0d pri=%0d score=%0d tag=%h fill=%0d last=%0b"},
                             exp_r.status, exp_r.pri, exp_r.score, exp_r.tag, exp_r.fill,
                             exp_r.last, act.status, act.pri, act.score, act.tag, act.fill,
                             act.last);
            end
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [sspl_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [sspl_pkg::KIND_W-1:0]       s_axis_tuser = sspl_pkg::KIND_INSERT;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [sspl_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              cfg_we = 1'b0;
    logic [sspl_pkg::CFG_IDX_W-1:0]    cfg_index = sspl_pkg::CFG_THR_TOP;
    logic [sspl_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    sorted_list_scoreboard sb = new();

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned hold_count = 0;
    longint      cycle_count = 0;

    stable_sorted_priority_list dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // output side: long hold-off once requested, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitors for both transfer sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic [sspl_pkg::KIND_W-1:0] kind,
                             input logic [sspl_pkg::SCORE_W-1:0] score,
                             input logic [sspl_pkg::TAG_W-1:0] tag);
        int unsigned gaps;
        gaps = 0;
        while ($urandom_range(99) < idle_pct && gaps < 20)
            gaps++;
        if (gaps > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {tag, score};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sspl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sspl_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_list(input logic [7:0] t_top, input logic [7:0] t_high,
                                input logic [7:0] t_mid, input logic [2:0] p_top,
                                input logic [2:0] p_high, input logic [2:0] p_mid,
                                input logic [2:0] p_low);
        write_reg(sspl_pkg::CFG_THR_TOP, t_top);
        write_reg(sspl_pkg::CFG_THR_HIGH, t_high);
        write_reg(sspl_pkg::CFG_THR_MID, t_mid);
        write_reg(sspl_pkg::CFG_PRI_TOP, {5'd0, p_top});
        write_reg(sspl_pkg::CFG_PRI_HIGH, {5'd0, p_high});
        write_reg(sspl_pkg::CFG_PRI_MID, {5'd0, p_mid});
        write_reg(sspl_pkg::CFG_PRI_LOW, {5'd0, p_low});
    endtask

    task automatic random_run(input int unsigned count);
        int unsigned done;
        int unsigned r;
        logic [sspl_pkg::SCORE_W-1:0] score;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(99);
            score = ($urandom_range(1)) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
            if (r < 70)
                send_item(sspl_pkg::KIND_INSERT, score, 16'($urandom));
            else if (r < 86)
                send_item(sspl_pkg::KIND_READ, score, 16'($urandom));
            else if (r < 93)
                send_item(sspl_pkg::KIND_CLEAR, score, 16'($urandom));
            else
                send_item(KIND_UNUSED, score, 16'($urandom));
            if (r < 93)
                done++;
        end
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, class boundaries, equal classes, overflow
        send_item(sspl_pkg::KIND_READ, 8'd0, 16'h0000);
        send_item(sspl_pkg::KIND_CLEAR, 8'd0, 16'h0000);
        send_item(sspl_pkg::KIND_INSERT, 8'd0, 16'h0000);
        send_item(sspl_pkg::KIND_INSERT, 8'd255, 16'hffff);
        send_item(sspl_pkg::KIND_INSERT, 8'd9, 16'h1111);
        send_item(sspl_pkg::KIND_INSERT, 8'd8, 16'h2222);
        send_item(sspl_pkg::KIND_INSERT, 8'd7, 16'h3333);
        send_item(sspl_pkg::KIND_INSERT, 8'd6, 16'h4444);
        send_item(sspl_pkg::KIND_INSERT, 8'd5, 16'h5555);
        send_item(sspl_pkg::KIND_INSERT, 8'd9, 16'h6666);
        send_item(sspl_pkg::KIND_INSERT, 8'd9, 16'h7777);
        send_item(KIND_UNUSED, 8'hff, 16'hffff);
        send_item(sspl_pkg::KIND_READ, 8'd0, 16'h0000);
        for (int i = 0; i < 7; i++)
            send_item(sspl_pkg::KIND_INSERT, 8'($urandom_range(12)), 16'($urandom));
        send_item(sspl_pkg::KIND_INSERT, 8'd200, 16'habcd);
        send_item(sspl_pkg::KIND_READ, 8'd0, 16'h0000);
        send_item(sspl_pkg::KIND_CLEAR, 8'hff, 16'hffff);
        send_item(sspl_pkg::KIND_READ, 8'd0, 16'h0000);
        drain();

        random_run(RUN_ITEMS);

        // high and mid thresholds both zero, extreme priorities
        program_list(8'd255, 8'd0, 8'd0, 3'd7, 3'd0, 3'd4, 3'd7);
        idle_pct = 60;
        random_run(RUN_ITEMS);

        program_list(8'd200, 8'd100, 8'd150, 3'd0, 3'd7, 3'd3, 3'd0);
        idle_pct = 0;
        stall_pct = 60;
        hold_req = 1'b1;
        random_run(RUN_ITEMS);

        program_list(8'($urandom_range(15)), 8'($urandom_range(15)), 8'($urandom_range(15)),
                     3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
        idle_pct = 16;
        stall_pct = 16;
        random_run(RUN_ITEMS);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
